// File: rtl/pva_pkg.sv
// ============================================================================
// pva_pkg: shared types and constants for the polar vector adder
// Fixed-point formats, the CORDIC arctangent table and the data carried
// from cell to cell along the rotation and vectoring chains.
// ============================================================================
package pva_pkg;

    // Component width: Q16 values with CORDIC growth and a sign bit
    localparam int XW = 37;
    // Angle width: degrees times 2^22
    localparam int ZW = 32;

    localparam int ATAN_ENTRIES     = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    // 1/K in Q24
    localparam logic [23:0] KINV_Q24 = 24'd10188014;

    // Input angle units (1/64 degree)
    localparam logic signed [16:0] ANG_IN_90  = 17'sd5760;
    localparam logic signed [16:0] ANG_IN_180 = 17'sd11520;
    localparam logic signed [16:0] ANG_IN_360 = 17'sd23040;

    // Internal angle units (degrees times 2^22)
    localparam logic signed [ZW-1:0] DEG90_Z  = 32'sd377487360;
    localparam logic signed [ZW-1:0] DEG180_Z = 32'sd754974720;

    // Output limits
    localparam logic [18:0]        LEN_MAX = 19'd524280;
    localparam logic signed [16:0] ANG_MAX = 17'sd11520;

    // atan(2^-i) in degrees times 2^22
    localparam logic signed [ZW-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29
    };

    // One vector in the rotation chain
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } rot_vec_t;

    // Both input vectors travel side by side
    typedef struct packed {
        rot_vec_t a;
        rot_vec_t b;
    } rot_pair_t;

    // Resultant in the vectoring chain
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } vec_data_t;

endpackage

// File: rtl/polar_vector_add.sv
// ============================================================================
// polar_vector_add: sum of two vectors given in polar form
// Stages, each a register: one prep stage, a chain of rotation cells, one
// combine stage, a chain of vectoring cells and two length scaling stages.
// Throughput is one vector pair per cycle while out_ready does not stall it;
// every stage holds its own item.
// Reset clears all valid bits; the data registers are not reset.
// ============================================================================
module polar_vector_add #(
    parameter int CORDIC_STEPS = pva_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic        [15:0] first_length,
    input  logic signed [15:0] first_angle,
    input  logic        [15:0] second_length,
    input  logic signed [15:0] second_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [18:0] result_length,
    output logic signed [14:0] result_angle
);

    localparam int NSTEPS = (CORDIC_STEPS > pva_pkg::ATAN_ENTRIES) ?
                            pva_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int XW = pva_pkg::XW;
    localparam int ZW = pva_pkg::ZW;

    // ------------------------------------------------------------------
    // Prep stage: wrap and fold the angle, scale the length by 1/K
    // ------------------------------------------------------------------
    function automatic pva_pkg::rot_vec_t prep_vector(
        input logic        [15:0] len,
        input logic signed [15:0] ang
    );
        pva_pkg::rot_vec_t  v;
        logic signed [16:0] a;
        logic        [39:0] prod;
        a    = {ang[15], ang};
        if (a >= pva_pkg::ANG_IN_180)
        begin
            a = a - pva_pkg::ANG_IN_360;
        end
        else if (a < -pva_pkg::ANG_IN_180)
        begin
            a = a + pva_pkg::ANG_IN_360;
        end
        v.flip = 1'b0;
        if (a > pva_pkg::ANG_IN_90)
        begin
            a      = a - pva_pkg::ANG_IN_180;
            v.flip = 1'b1;
        end
        else if (a < -pva_pkg::ANG_IN_90)
        begin
            a      = a + pva_pkg::ANG_IN_180;
            v.flip = 1'b1;
        end
        prod = 40'(len) * 40'(pva_pkg::KINV_Q24) + 40'd128;
        v.x  = signed'({5'b0, prod[39:8]});
        v.y  = '0;
        v.z  = signed'({a[15:0], 16'b0});
        return v;
    endfunction

    logic               prep_valid_reg;
    logic               prep_ready;
    pva_pkg::rot_pair_t prep_data_reg;
    pva_pkg::rot_pair_t prep_data_next;

    logic               rot_valid [NSTEPS+1];
    logic               rot_ready [NSTEPS+1];
    pva_pkg::rot_pair_t rot_data  [NSTEPS+1];

    always_comb
    begin
        prep_data_next.a = prep_vector(first_length, first_angle);
        prep_data_next.b = prep_vector(second_length, second_angle);
    end

    assign prep_ready = !prep_valid_reg || rot_ready[0];
    assign in_ready   = prep_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (prep_ready)
        begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && prep_ready)
        begin
            prep_data_reg <= prep_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Rotation chain
    // ------------------------------------------------------------------
    assign rot_valid[0] = prep_valid_reg;
    assign rot_data[0]  = prep_data_reg;

    for (genvar g = 0; g < NSTEPS; g++)
    begin : g_rot
        pva_rot_cell #(
            .STEP (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rot_valid[g]),
            .in_ready  (rot_ready[g]),
            .in_data   (rot_data[g]),
            .out_valid (rot_valid[g+1]),
            .out_ready (rot_ready[g+1]),
            .out_data  (rot_data[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Combine stage: undo the fold, sum components, set up vectoring
    // ------------------------------------------------------------------
    logic               comb_valid_reg;
    logic               comb_ready;
    pva_pkg::vec_data_t comb_data_reg;
    pva_pkg::vec_data_t comb_data_next;

    logic               vec_valid [NSTEPS+1];
    logic               vec_ready [NSTEPS+1];
    pva_pkg::vec_data_t vec_data  [NSTEPS+1];

    logic signed [XW-1:0] x1;
    logic signed [XW-1:0] y1;
    logic signed [XW-1:0] x2;
    logic signed [XW-1:0] y2;
    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;

    always_comb
    begin
        x1 = rot_data[NSTEPS].a.flip ? -rot_data[NSTEPS].a.x : rot_data[NSTEPS].a.x;
        y1 = rot_data[NSTEPS].a.flip ? -rot_data[NSTEPS].a.y : rot_data[NSTEPS].a.y;
        x2 = rot_data[NSTEPS].b.flip ? -rot_data[NSTEPS].b.x : rot_data[NSTEPS].b.x;
        y2 = rot_data[NSTEPS].b.flip ? -rot_data[NSTEPS].b.y : rot_data[NSTEPS].b.y;
        sx = x1 + x2;
        sy = y1 + y2;
        comb_data_next.zero = (sx == '0) && (sy == '0);
        comb_data_next.x    = sx;
        comb_data_next.y    = sy;
        comb_data_next.z    = '0;
        // Left half plane: negate and start from +-180 degrees
        if (sx[XW-1])
        begin
            comb_data_next.x = -sx;
            comb_data_next.y = -sy;
            comb_data_next.z = sy[XW-1] ? -pva_pkg::DEG180_Z : pva_pkg::DEG180_Z;
        end
    end

    assign comb_ready        = !comb_valid_reg || vec_ready[0];
    assign rot_ready[NSTEPS] = comb_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_valid_reg <= 1'b0;
        end
        else if (comb_ready)
        begin
            comb_valid_reg <= rot_valid[NSTEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rot_valid[NSTEPS] && comb_ready)
        begin
            comb_data_reg <= comb_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Vectoring chain
    // ------------------------------------------------------------------
    assign vec_valid[0] = comb_valid_reg;
    assign vec_data[0]  = comb_data_reg;

    for (genvar g = 0; g < NSTEPS; g++)
    begin : g_vec
        pva_vec_cell #(
            .STEP (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vec_valid[g]),
            .in_ready  (vec_ready[g]),
            .in_data   (vec_data[g]),
            .out_valid (vec_valid[g+1]),
            .out_ready (vec_ready[g+1]),
            .out_data  (vec_data[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Scale stage 1: split x into two partial products, round and clamp the angle
    // ------------------------------------------------------------------
    logic               sc_valid_reg;
    logic               sc_ready;
    logic               fin_ready;
    logic        [41:0] phi_reg;
    logic        [41:0] phi_next;
    logic        [41:0] plo_reg;
    logic        [41:0] plo_next;
    logic               zero_reg;
    logic signed [14:0] ang_reg;
    logic signed [14:0] ang_next;

    logic        [XW-1:0] xc;
    logic signed [ZW:0]   zr;
    logic signed [16:0]   ar;

    always_comb
    begin
        xc       = vec_data[NSTEPS].x[XW-1] ? '0 : vec_data[NSTEPS].x;
        phi_next = 42'(xc[35:18]) * 42'(pva_pkg::KINV_Q24);
        plo_next = 42'(xc[17:0]) * 42'(pva_pkg::KINV_Q24);
        zr       = {vec_data[NSTEPS].z[ZW-1], vec_data[NSTEPS].z} + 33'sd32768;
        ar       = zr[ZW:16];
        if (ar > pva_pkg::ANG_MAX)
        begin
            ar = pva_pkg::ANG_MAX;
        end
        else if (ar < -pva_pkg::ANG_MAX)
        begin
            ar = -pva_pkg::ANG_MAX;
        end
        ang_next = vec_data[NSTEPS].zero ? '0 : ar[14:0];
    end

    assign sc_ready          = !sc_valid_reg || fin_ready;
    assign vec_ready[NSTEPS] = sc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
        end
        else if (sc_ready)
        begin
            sc_valid_reg <= vec_valid[NSTEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vec_valid[NSTEPS] && sc_ready)
        begin
            phi_reg  <= phi_next;
            plo_reg  <= plo_next;
            zero_reg <= vec_data[NSTEPS].zero;
            ang_reg  <= ang_next;
        end
    end

    // ------------------------------------------------------------------
    // Scale stage 2: add partial products, round to quarter units, saturate
    // ------------------------------------------------------------------
    logic               fin_valid_reg;
    logic        [18:0] len_reg;
    logic        [18:0] len_next;
    logic signed [14:0] fang_reg;
    logic        [59:0] lsum;

    always_comb
    begin
        lsum = {phi_reg[41:0], 18'b0} + 60'(plo_reg) + (60'd1 << 37);
        if (zero_reg)
        begin
            len_next = '0;
        end
        else if (lsum[59:38] > 22'(pva_pkg::LEN_MAX))
        begin
            len_next = pva_pkg::LEN_MAX;
        end
        else
        begin
            len_next = lsum[56:38];
        end
    end

    assign fin_ready = !fin_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            fin_valid_reg <= sc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_valid_reg && fin_ready)
        begin
            len_reg  <= len_next;
            fang_reg <= ang_reg;
        end
    end

    assign out_valid     = fin_valid_reg;
    assign result_length = len_reg;
    assign result_angle  = fang_reg;

`ifndef SYNTHESIS
    // Folded angles stay within a quarter turn
    a_prep_fold: assert property (@(posedge clk) disable iff (!rst_n)
        prep_valid_reg |->
            (prep_data_reg.a.z <= pva_pkg::DEG90_Z) &&
            (prep_data_reg.a.z >= -pva_pkg::DEG90_Z) &&
            (prep_data_reg.b.z <= pva_pkg::DEG90_Z) &&
            (prep_data_reg.b.z >= -pva_pkg::DEG90_Z))
        else $error("folded angle outside quarter turn");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (result_length <= pva_pkg::LEN_MAX) &&
            (result_angle <= 15'sd11520) && (result_angle >= -15'sd11520))
        else $error("result outside its range");

    // A zero resultant leaves the scale stage with angle zero
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        sc_valid_reg && zero_reg |-> (ang_reg == '0))
        else $error("zero resultant with nonzero angle");

    // A held result must not let the final stage take a new item
    a_hold_final: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !out_ready |=> fin_valid_reg && $stable(len_reg))
        else $error("final stage dropped a held result");
`endif

endmodule

// File: rtl/pva_rot_cell.sv
// ============================================================================
// pva_rot_cell: one CORDIC rotation step for both input vectors
// Registers a single micro-rotation by atan(2^-STEP) toward zero residual
// angle and hands the result to the next cell with valid/ready.
// ============================================================================
module pva_rot_cell #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pva_pkg::rot_pair_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pva_pkg::rot_pair_t  out_data
);

    localparam logic signed [pva_pkg::ZW-1:0] ATAN_Z = pva_pkg::ATAN_TABLE[STEP];

    logic               valid_reg;
    pva_pkg::rot_pair_t data_reg;
    pva_pkg::rot_pair_t data_next;

    function automatic pva_pkg::rot_vec_t rotate(input pva_pkg::rot_vec_t v);
        pva_pkg::rot_vec_t              r;
        logic signed [pva_pkg::XW-1:0] x;
        logic signed [pva_pkg::XW-1:0] y;
        logic signed [pva_pkg::ZW-1:0] z;
        logic signed [pva_pkg::XW-1:0] dx;
        logic signed [pva_pkg::XW-1:0] dy;
        x  = v.x;
        y  = v.y;
        z  = v.z;
        dx = y >>> STEP;
        dy = x >>> STEP;
        r  = v;
        if (!z[pva_pkg::ZW-1])
        begin
            r.x = x - dx;
            r.y = y + dy;
            r.z = z - ATAN_Z;
        end
        else
        begin
            r.x = x + dx;
            r.y = y - dy;
            r.z = z + ATAN_Z;
        end
        return r;
    endfunction

    always_comb
    begin
        data_next.a = rotate(in_data.a);
        data_next.b = rotate(in_data.b);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/pva_vec_cell.sv
// ============================================================================
// pva_vec_cell: one CORDIC vectoring step on the resultant
// Registers a single micro-rotation that drives y toward zero and
// accumulates the angle, then hands the result to the next cell.
// ============================================================================
module pva_vec_cell #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pva_pkg::vec_data_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pva_pkg::vec_data_t  out_data
);

    localparam logic signed [pva_pkg::ZW-1:0] ATAN_Z = pva_pkg::ATAN_TABLE[STEP];

    logic               valid_reg;
    pva_pkg::vec_data_t data_reg;
    pva_pkg::vec_data_t data_next;

    logic signed [pva_pkg::XW-1:0] x;
    logic signed [pva_pkg::XW-1:0] y;
    logic signed [pva_pkg::ZW-1:0] z;
    logic signed [pva_pkg::XW-1:0] dx;
    logic signed [pva_pkg::XW-1:0] dy;

    always_comb
    begin
        x  = in_data.x;
        y  = in_data.y;
        z  = in_data.z;
        dx = y >>> STEP;
        dy = x >>> STEP;
        data_next = in_data;
        if (!y[pva_pkg::XW-1])
        begin
            data_next.x = x + dx;
            data_next.y = y - dy;
            data_next.z = z + ATAN_Z;
        end
        else
        begin
            data_next.x = x - dx;
            data_next.y = y + dy;
            data_next.z = z - ATAN_Z;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: tb/testbench.sv
// ============================================================================
// testbench: polar vector adder check
// Sends vector pairs in polar form, works out the resultant length and
// direction with a bit-exact fixed-point CORDIC predictor, and compares every
// result field by field. Covers corner angles and lengths, output back-pressure
// that fills the pipeline, and random traffic with bursty input and stalls.
// ============================================================================
module testbench;

    localparam int STEPS          = pva_pkg::CORDIC_STEPS_DEF;
    localparam int STEPS_RUN      = (STEPS > 24) ? 24 : STEPS;
    localparam int LATENCY        = 2 * STEPS + 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PAIRS   = 970;
    localparam int MAX_REPORTS    = 30;

    localparam longint DEG90_Q22     = 64'sd377487360;
    localparam longint DEG180_Q22    = 64'sd754974720;
    localparam longint DEG360_Q22    = 64'sd1509949440;
    localparam logic [63:0] GAIN_INV = 64'd10188014;
    localparam logic [63:0] LEN_SAT  = 64'd524280;
    localparam longint ANG_LIMIT     = 64'sd11520;

    localparam logic signed [15:0] A90  = 16'sd5760;
    localparam logic signed [15:0] A180 = 16'sd11520;
    localparam logic signed [15:0] A360 = 16'sd23040;
    localparam logic [15:0]        LMAX = 16'd65535;

    typedef struct packed {
        logic        [18:0] len;
        logic signed [14:0] ang;
    } resultant_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic        [15:0] first_length  = '0;
    logic signed [15:0] first_angle   = '0;
    logic        [15:0] second_length = '0;
    logic signed [15:0] second_angle  = '0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic        [18:0] result_length;
    logic signed [14:0] result_angle;

    resultant_t expected_sums[$];
    int mismatches     = 0;
    int pairs_sent     = 0;
    int sums_checked   = 0;
    int zero_sums      = 0;
    int saturated_sums = 0;
    int idle_cycles    = 0;
    int holds_done     = 0;

    // Receiver hold-off request: flip to start one long stall
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    logic [31:0] ready_pattern = 32'hFFFF_FFFF;
    int   pattern_age = 0;

    polar_vector_add #(
        .CORDIC_STEPS(STEPS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_length (first_length),
        .first_angle  (first_angle),
        .second_length(second_length),
        .second_angle (second_angle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_length(result_length),
        .result_angle (result_angle)
    );

    always #2 clk = ~clk;

    // atan(2^-i) in degrees times 2^22
    function automatic longint atan_deg22(input int i);
        case (i)
            0:  return 188743680;
            1:  return 111421900;
            2:  return 58872272;
            3:  return 29884485;
            4:  return 15000234;
            5:  return 7507429;
            6:  return 3754631;
            7:  return 1877430;
            8:  return 938729;
            9:  return 469366;
            10: return 234683;
            11: return 117342;
            12: return 58671;
            13: return 29335;
            14: return 14668;
            15: return 7334;
            16: return 3667;
            17: return 1833;
            18: return 917;
            19: return 458;
            20: return 229;
            21: return 115;
            22: return 57;
            default: return 29;
        endcase
    endfunction

    // Rotate a gain-corrected length onto its direction; components in Q16
    function automatic void polar_to_xy(input logic [15:0] len,
                                        input logic signed [15:0] ang,
                                        output longint px, output longint py);
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [63:0] scaled;
        bit          flip;
        int          i;
        z = longint'(ang) * 64'sd65536;
        if (z >= DEG180_Q22) z -= DEG360_Q22;
        if (z >= DEG180_Q22) z -= DEG360_Q22;
        if (z < -DEG180_Q22) z += DEG360_Q22;
        if (z < -DEG180_Q22) z += DEG360_Q22;
        flip = 1'b0;
        // fold the back half plane onto the front and negate afterwards
        if (z > DEG90_Q22) begin
            z -= DEG180_Q22;
            flip = 1'b1;
        end else if (z < -DEG90_Q22) begin
            z += DEG180_Q22;
            flip = 1'b1;
        end
        scaled = ({48'd0, len} * GAIN_INV + 64'd128) >> 8;
        x = longint'(scaled);
        y = 0;
        for (i = 0; i < STEPS_RUN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_deg22(i);
            end else begin
                x += dx;
                y -= dy;
                z += atan_deg22(i);
            end
        end
        px = flip ? -x : x;
        py = flip ? -y : y;
    endfunction

    function automatic resultant_t predict_sum(input logic [15:0] len_a,
                                               input logic signed [15:0] ang_a,
                                               input logic [15:0] len_b,
                                               input logic signed [15:0] ang_b);
        longint      xa;
        longint      ya;
        longint      xb;
        longint      yb;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      ang;
        logic [63:0] mag;
        resultant_t  res;
        int          i;
        polar_to_xy(len_a, ang_a, xa, ya);
        polar_to_xy(len_b, ang_b, xb, yb);
        x = xa + xb;
        y = ya + yb;
        res = '0;
        if (x == 0 && y == 0) return res;
        z = 0;
        // left half plane: mirror through the origin and start from +-180
        if (x < 0) begin
            z = (y >= 0) ? DEG180_Q22 : -DEG180_Q22;
            x = -x;
            y = -y;
        end
        for (i = 0; i < STEPS_RUN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += atan_deg22(i);
            end else begin
                x -= dx;
                y += dy;
                z -= atan_deg22(i);
            end
        end
        if (x < 0) x = 0;
        mag = (64'(x) * GAIN_INV + (64'd1 << 37)) >> 38;
        if (mag > LEN_SAT) mag = LEN_SAT;
        ang = (z + 64'sd32768) >>> 16;
        if (ang > ANG_LIMIT) ang = ANG_LIMIT;
        if (ang < -ANG_LIMIT) ang = -ANG_LIMIT;
        res.len = mag[18:0];
        res.ang = ang[14:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Offer one pair and hold it until the transfer; valid stays high after
    task automatic send_pair(input logic [15:0] len_a, input logic signed [15:0] ang_a,
                             input logic [15:0] len_b, input logic signed [15:0] ang_b);
        resultant_t want;
        first_length  <= len_a;
        first_angle   <= ang_a;
        second_length <= len_b;
        second_angle  <= ang_b;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        want = predict_sum(len_a, ang_a, len_b, ang_b);
        if (want.len == 19'd0 && want.ang == 15'sd0) zero_sums++;
        if (64'(want.len) == LEN_SAT) saturated_sums++;
        expected_sums.push_back(want);
        pairs_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] pick_length();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 15));
            1: return LMAX - 16'($urandom_range(0, 15));
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom);
            2: begin
                case ($urandom_range(0, 8))
                    0: return 16'sd0;
                    1: return A90;
                    2: return -A90;
                    3: return A180;
                    4: return -A180;
                    5: return A360;
                    6: return -A360;
                    7: return A90 + 16'sd1;
                    default: return -A90 - 16'sd1;
                endcase
            end
            default: return 16'($urandom_range(0, 46080) - 23040);
        endcase
    endfunction

    task automatic test_corner_vectors();
        send_pair(16'd0, 16'sd0, 16'd0, 16'sd0);
        send_pair(LMAX, 16'sd0, LMAX, 16'sd0);
        send_pair(LMAX, A180, LMAX, A180);
        send_pair(LMAX, -A180, 16'd0, 16'sd0);
        send_pair(16'd1000, A90, 16'd1000, -A90);
        send_pair(16'd500, 16'sd0, 16'd500, A180);
        send_pair(16'd1000, 16'sd10880, 16'd1000, -16'sd10880);
        send_pair(16'd1000, 16'sd10000, 16'd0, 16'sd0);
        send_pair(16'd1000, -16'sd10000, 16'd0, 16'sd0);
        send_pair(16'd12345, A360, 16'd0, 16'sd0);
        send_pair(16'd12345, -A360, 16'd0, 16'sd0);
        send_pair(16'd40000, 16'sh7FFF, 16'd30000, 16'sh8000);
        send_pair(16'd1, 16'sd2880, 16'd1, -16'sd2880);
        send_pair(LMAX, A90 + 16'sd1, LMAX, -A90 - 16'sd1);
        send_pair(LMAX, A90, 16'd0, 16'sd0);
        send_pair(16'd0, 16'sd12345, 16'd0, -16'sd777);
        send_pair(LMAX, A180 - 16'sd1, LMAX, -A180);
        send_pair(LMAX, A360, LMAX, -A360);
        send_pair(16'd1, A180, 16'd0, 16'sd0);
    endtask

    // Stall the output for a long stretch while pairs keep coming
    task automatic test_output_backpressure();
        int n;
        hold_toggle <= ~hold_toggle;
        for (n = 0; n < 3 * LATENCY; n++)
            send_pair(pick_length(), pick_angle(), pick_length(), pick_angle());
    endtask

    task automatic test_random_traffic(input int count);
        int          n;
        int          burst_left;
        logic [15:0] len_a;
        logic [15:0] len_b;
        logic signed [15:0] ang_a;
        logic signed [15:0] ang_b;
        burst_left = $urandom_range(1, 24);
        for (n = 0; n < count; n++) begin
            len_a = pick_length();
            ang_a = pick_angle();
            len_b = pick_length();
            ang_b = pick_angle();
            // near-cancelling pairs: opposite directions, similar lengths
            if ($urandom_range(0, 9) == 0) begin
                len_b = len_a ^ 16'($urandom_range(0, 3));
                ang_b = (ang_a > 16'sd0) ? ang_a - A180 : ang_a + A180;
            end
            send_pair(len_a, ang_a, len_b, ang_b);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                // keep some stretches free of input gaps
                if ((n % 300) >= 80 && $urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 6));
            end
        end
    endtask

    // Receiver: a rotating ready pattern, reloaded now and then, plus hold-offs
    always @(posedge clk) begin : ready_driver
        logic [31:0] fresh;
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
            holds_done++;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0: fresh = 32'hFFFF_FFFF;
                1: fresh = $urandom;
                2: fresh = $urandom | $urandom;
                default: fresh = ($urandom & $urandom) | 32'd1;
            endcase
            ready_pattern <= {fresh[0], fresh[31:1]};
            out_ready     <= fresh[0];
            pattern_age   <= $urandom_range(16, 96);
        end else begin
            ready_pattern <= {ready_pattern[0], ready_pattern[31:1]};
            out_ready     <= ready_pattern[0];
            pattern_age   <= pattern_age - 1;
        end
    end

    always @(posedge clk) begin : result_check
        resultant_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected result len=%0d ang=%0d",
                                          result_length, result_angle));
            end else begin
                want = expected_sums.pop_front();
                if (result_length !== want.len)
                    report_mismatch($sformatf("result_length %0d, expected %0d",
                                              result_length, want.len));
                if (result_angle !== want.ang)
                    report_mismatch($sformatf("result_angle %0d, expected %0d",
                                              result_angle, want.ang));
            end
            sums_checked++;
        end
    end

    always @(posedge clk) begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_sums.size());
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic finish_run();
        while (expected_sums.size() != 0) @(posedge clk);
        // catch any stray result trailing the last one
        repeat (2 * LATENCY) @(posedge clk);
        $display("Sent %0d vector pairs, %0d results checked, %0d output hold-offs.",
                 pairs_sent, sums_checked, holds_done);
        $display("Zero resultants: %0d, saturated lengths: %0d, mismatches: %0d.",
                 zero_sums, saturated_sums, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_vectors();
        test_output_backpressure();
        test_random_traffic(RANDOM_PAIRS);
        in_valid <= 1'b0;
        finish_run();
    end

endmodule
